[hdl/bdts_pkg.sv]
// ----------------------------------------------------------------------------
// bdts_pkg
// Shared constants for the best distance threshold scorer.
// ----------------------------------------------------------------------------
package bdts_pkg;

    localparam int MAX_CANDIDATES_DEF = 64;
    localparam int MAX_VARS_DEF       = 32;

    localparam int FIT_W   = 32;
    localparam int VAR_W   = 16;
    localparam int THR_W   = 17;
    localparam int SLOT_W  = 3;
    localparam int CIDX_W  = 6;
    localparam int DIST_W  = 20;
    localparam int CFGA_W  = 2;
    localparam int CFGD_W  = 32;

    // configuration register indexes
    localparam logic [CFGA_W-1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [CFGA_W-1:0] REG_SHIFT_VALUE = 2'd1;
    localparam logic [CFGA_W-1:0] REG_MAXIMIZE    = 2'd2;
    localparam logic [CFGA_W-1:0] REG_RESULT_SLOT = 2'd3;

    localparam logic [THR_W-1:0]  THRESHOLD_RST   = 17'h10000;
    localparam logic [SLOT_W-1:0] RESULT_SLOT_RST = 3'd1;

endpackage

[hdl/best_distance_threshold_scorer.sv]
// ----------------------------------------------------------------------------
// best_distance_threshold_scorer
// Distance of each loaded candidate to the best one, gated by a fitness
// ratio test.
// ----------------------------------------------------------------------------
// Input side is a queue: drive an item (one variable) with i_push while
// o_full is low. One item is taken per cycle while loading. i_last_var ends
// a candidate (its fitness is taken then); i_last_item ends the batch.
// After the last item o_full stays high while the front walks every stored
// candidate: the ratio test (fitness RAM read, subtract, 33x18 multiply,
// compare), then, when the test passes, a pass per variable of the best
// candidate (two reads of the one variable RAM port, subtract, square,
// accumulate), then a state that hands the job on. Jobs go through a
// two-entry queue to the square root unit, which works on one job at a
// time while the front goes on; it takes a new job only once the last
// result has moved to the output register. After the walk, full drops
// and loading resumes.
// Results come out in load order on the output queue (o_empty / i_pop);
// a stalled receiver holds the result and, once the job queue fills,
// stalls the front as well. Configuration writes are taken at any clock
// edge with i_cfg_we, but are meant for idle periods. Reset (synchronous,
// active low) empties all queues and clears the batch; stored variables
// and fitnesses are left as they are.
// ----------------------------------------------------------------------------
module best_distance_threshold_scorer #(
    parameter int MAX_CANDIDATES = bdts_pkg::MAX_CANDIDATES_DEF,
    parameter int MAX_VARS       = bdts_pkg::MAX_VARS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bdts_pkg::CFGA_W-1:0]    i_cfg_index,
    input  logic [bdts_pkg::CFGD_W-1:0]    i_cfg_wdata,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [bdts_pkg::FIT_W-1:0]     i_fitness,
    input  logic [bdts_pkg::VAR_W-1:0]     i_var_value,
    input  logic                           i_last_var,
    input  logic                           i_last_item,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [bdts_pkg::CIDX_W-1:0]    o_candidate_index,
    output logic [bdts_pkg::DIST_W-1:0]    o_distance,
    output logic [bdts_pkg::SLOT_W-1:0]    o_objective_slot,
    output logic                           o_last_result
);

    localparam int IW    = $clog2(MAX_CANDIDATES);
    // summed squares of 17-bit differences, rounded up to an even width
    localparam int ACC_W = 32 + 2 * (($clog2(MAX_VARS) + 1) / 2);
    localparam int JOB_W = IW + ACC_W + 1;

    logic [bdts_pkg::THR_W-1:0]  r_threshold;
    logic [bdts_pkg::FIT_W-1:0]  r_shift_value;
    logic                        r_maximize;
    logic [bdts_pkg::SLOT_W-1:0] r_result_slot;

    logic                f_valid, f_ready, q_full, q_empty, b_ready;
    logic [IW-1:0]       f_idx, q_idx, b_idx;
    logic [ACC_W-1:0]    f_acc, q_acc;
    logic                f_last, q_last, b_last;
    logic [JOB_W-1:0]    q_rdata;
    logic [ACC_W/2-1:0]  b_root;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= bdts_pkg::THRESHOLD_RST;
            r_shift_value <= '0;
            r_maximize    <= 1'b0;
            r_result_slot <= bdts_pkg::RESULT_SLOT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bdts_pkg::REG_THRESHOLD:   r_threshold   <= i_cfg_wdata[16:0];
                bdts_pkg::REG_SHIFT_VALUE: r_shift_value <= i_cfg_wdata;
                bdts_pkg::REG_MAXIMIZE:    r_maximize    <= i_cfg_wdata[0];
                bdts_pkg::REG_RESULT_SLOT: r_result_slot <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    bdts_front #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .MAX_VARS       (MAX_VARS),
        .IW             (IW),
        .ACC_W          (ACC_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_threshold   (r_threshold),
        .i_shift_value (r_shift_value),
        .i_maximize    (r_maximize),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_fitness     (i_fitness),
        .i_var_value   (i_var_value),
        .i_last_var    (i_last_var),
        .i_last_item   (i_last_item),
        .o_job_valid   (f_valid),
        .i_job_ready   (f_ready),
        .o_job_idx     (f_idx),
        .o_job_acc     (f_acc),
        .o_job_last    (f_last)
    );

    assign f_ready = !q_full;

    bdts_fifo #(.WIDTH(JOB_W)) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .i_wdata ({f_idx, f_acc, f_last}),
        .o_full  (q_full),
        .i_rd    (b_ready),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign {q_idx, q_acc, q_last} = q_rdata;

    bdts_back #(.IW(IW), .ACC_W(ACC_W)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .o_job_ready (b_ready),
        .i_job_idx   (q_idx),
        .i_job_acc   (q_acc),
        .i_job_last  (q_last),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_idx       (b_idx),
        .o_root      (b_root),
        .o_last      (b_last)
    );

    assign o_candidate_index = bdts_pkg::CIDX_W'(b_idx);
    assign o_distance        = bdts_pkg::DIST_W'(b_root);
    assign o_objective_slot  = r_result_slot;
    assign o_last_result     = b_last;

endmodule

[hdl/bdts_ram.sv]
// ----------------------------------------------------------------------------
// bdts_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/bdts_fifo.sv]
// ----------------------------------------------------------------------------
// bdts_fifo
// Two-entry job queue between the front sequencer and the root unit.
// ----------------------------------------------------------------------------
module bdts_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             wr_ok, rd_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rdata = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_ok) r_wp <= ~r_wp;
            if (rd_ok) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr_ok) - 2'(rd_ok);
        end
    end

endmodule

[hdl/bdts_front.sv]
// ----------------------------------------------------------------------------
// bdts_front
// Loads candidates, tracks the best, then walks the stores per candidate:
// threshold test and summed squared differences, handed on as jobs.
// ----------------------------------------------------------------------------
module bdts_front #(
    parameter int MAX_CANDIDATES = bdts_pkg::MAX_CANDIDATES_DEF,
    parameter int MAX_VARS       = bdts_pkg::MAX_VARS_DEF,
    parameter int IW             = 6,
    parameter int ACC_W          = 38
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bdts_pkg::THR_W-1:0]    i_threshold,
    input  logic [bdts_pkg::FIT_W-1:0]    i_shift_value,
    input  logic                          i_maximize,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [bdts_pkg::FIT_W-1:0]    i_fitness,
    input  logic [bdts_pkg::VAR_W-1:0]    i_var_value,
    input  logic                          i_last_var,
    input  logic                          i_last_item,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output logic [IW-1:0]                 o_job_idx,
    output logic [ACC_W-1:0]              o_job_acc,
    output logic                          o_job_last
);

    localparam int CW  = $clog2(MAX_CANDIDATES + 1);
    localparam int PW  = $clog2(MAX_VARS + 1);
    localparam int JW  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int VD  = MAX_CANDIDATES * MAX_VARS;
    localparam int VAW = $clog2(VD);
    localparam int FAW = $clog2(MAX_CANDIDATES);
    localparam int PRW = 51;

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_FRD  = 4'd1;
    localparam logic [3:0] S_FSUB = 4'd2;
    localparam logic [3:0] S_FMUL = 4'd3;
    localparam logic [3:0] S_FCMP = 4'd4;
    localparam logic [3:0] S_VA   = 4'd5;
    localparam logic [3:0] S_VB   = 4'd6;
    localparam logic [3:0] S_VC   = 4'd7;
    localparam logic [3:0] S_VD   = 4'd8;
    localparam logic [3:0] S_VE   = 4'd9;
    localparam logic [3:0] S_PUSH = 4'd10;

    localparam logic [VAW-1:0] MV_A = VAW'(MAX_VARS);
    localparam logic [CW-1:0]  MC_C = CW'(MAX_CANDIDATES);
    localparam logic [PW-1:0]  MV_P = PW'(MAX_VARS);

    logic [3:0]        r_state;
    logic [CW-1:0]     r_count;
    logic [PW-1:0]     r_pos, r_vpc, r_j;
    logic [IW-1:0]     r_best_idx, r_i;
    logic [bdts_pkg::FIT_W-1:0] r_best_fit;
    logic [bdts_pkg::VAR_W-1:0] r_a;
    logic signed [16:0] r_diff;
    logic [31:0]       r_sq;
    logic [ACC_W-1:0]  r_acc;
    logic signed [32:0] r_fd, r_bd;
    logic signed [PRW-1:0] r_prod, r_sh;

    logic              accept, can_store, end_cand, better;
    logic              var_we, fit_we;
    logic [VAW-1:0]    var_waddr, var_raddr;
    logic [IW-1:0]     rd_cand;
    logic [bdts_pkg::VAR_W-1:0] var_rdata;
    logic [bdts_pkg::FIT_W-1:0] fit_rdata;
    logic signed [32:0] mul_op;
    logic signed [33:0] sq_full;
    logic              is_last;

    assign o_full    = (r_state != S_LOAD);
    assign accept    = i_push && !o_full;
    assign can_store = (r_count < MC_C);
    assign end_cand  = i_last_var || i_last_item;
    assign better    = i_maximize ? ($signed(i_fitness) > $signed(r_best_fit))
                                  : ($signed(i_fitness) < $signed(r_best_fit));

    assign var_we    = accept && can_store && (r_pos < MV_P);
    assign fit_we    = accept && can_store && end_cand;
    assign var_waddr = VAW'(r_count[FAW-1:0]) * MV_A + VAW'(r_pos[JW-1:0]);
    assign rd_cand   = (r_state == S_VA) ? r_best_idx : r_i;
    assign var_raddr = VAW'(rd_cand[FAW-1:0]) * MV_A + VAW'(r_j[JW-1:0]);

    bdts_ram #(.WIDTH(bdts_pkg::VAR_W), .DEPTH(VD)) u_var_ram (
        .i_clk   (i_clk),
        .i_we    (var_we),
        .i_waddr (var_waddr),
        .i_wdata (i_var_value),
        .i_raddr (var_raddr),
        .o_rdata (var_rdata)
    );

    bdts_ram #(.WIDTH(bdts_pkg::FIT_W), .DEPTH(MAX_CANDIDATES)) u_fit_ram (
        .i_clk   (i_clk),
        .i_we    (fit_we),
        .i_waddr (r_count[FAW-1:0]),
        .i_wdata (i_fitness),
        .i_raddr (r_i[FAW-1:0]),
        .o_rdata (fit_rdata)
    );

    assign mul_op  = i_maximize ? r_bd : r_fd;
    assign sq_full = r_diff * r_diff;
    assign is_last = ((CW'(r_i) + CW'(1)) == r_count);

    assign o_job_valid = (r_state == S_PUSH);
    assign o_job_idx   = r_i;
    assign o_job_acc   = r_acc;
    assign o_job_last  = is_last;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_FSUB) begin
            r_fd <= $signed({fit_rdata[31], fit_rdata})
                    - $signed({i_shift_value[31], i_shift_value});
            r_bd <= $signed({r_best_fit[31], r_best_fit})
                    - $signed({i_shift_value[31], i_shift_value});
        end
        if (r_state == S_FMUL) begin
            r_prod <= PRW'(mul_op * $signed({1'b0, i_threshold}));
            r_sh   <= PRW'(i_maximize ? r_fd : r_bd) <<< 16;
        end
        if (r_state == S_VB) r_a <= var_rdata;
        if (r_state == S_VC) begin
            r_diff <= $signed({r_a[15], r_a}) - $signed({var_rdata[15], var_rdata});
        end
        if (r_state == S_VD) r_sq <= sq_full[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_count    <= '0;
            r_pos      <= '0;
            r_vpc      <= '0;
            r_best_idx <= '0;
            r_best_fit <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_acc      <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (can_store) begin
                            if (r_pos < MV_P) r_pos <= r_pos + PW'(1);
                            if (end_cand) begin
                                if (r_count == '0 || better) begin
                                    r_best_idx <= r_count[IW-1:0];
                                    r_best_fit <= i_fitness;
                                    r_vpc      <= (r_pos < MV_P) ? r_pos + PW'(1) : r_pos;
                                end
                                r_count <= r_count + CW'(1);
                                r_pos   <= '0;
                            end
                        end
                        if (i_last_item) begin
                            r_i     <= '0;
                            r_state <= S_FRD;
                        end
                    end
                end
                S_FRD:  r_state <= S_FSUB;
                S_FSUB: r_state <= S_FMUL;
                S_FMUL: r_state <= S_FCMP;
                S_FCMP: begin
                    r_acc <= '0;
                    r_j   <= '0;
                    // pass when the cross-multiplied product does not exceed
                    // the shifted side, in either direction
                    if ((r_prod <= r_sh) && (r_vpc != '0)) r_state <= S_VA;
                    else                                   r_state <= S_PUSH;
                end
                S_VA: r_state <= S_VB;
                S_VB: r_state <= S_VC;
                S_VC: r_state <= S_VD;
                S_VD: r_state <= S_VE;
                S_VE: begin
                    r_acc <= r_acc + ACC_W'(r_sq);
                    r_j   <= r_j + PW'(1);
                    if ((r_j + PW'(1)) == r_vpc) r_state <= S_PUSH;
                    else                         r_state <= S_VA;
                end
                S_PUSH: begin
                    if (i_job_ready) begin
                        if (is_last) begin
                            r_count    <= '0;
                            r_pos      <= '0;
                            r_vpc      <= '0;
                            r_best_idx <= '0;
                            r_best_fit <= '0;
                            r_state    <= S_LOAD;
                        end else begin
                            r_i     <= r_i + IW'(1);
                            r_state <= S_FRD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule

[hdl/bdts_back.sv]
// ----------------------------------------------------------------------------
// bdts_back
// Digit-by-digit square root, two radicand bits a cycle, feeding the
// result register.
// ----------------------------------------------------------------------------
module bdts_back #(
    parameter int IW    = 6,
    parameter int ACC_W = 38
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    output logic                  o_job_ready,
    input  logic [IW-1:0]         i_job_idx,
    input  logic [ACC_W-1:0]      i_job_acc,
    input  logic                  i_job_last,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [IW-1:0]         o_idx,
    output logic [ACC_W/2-1:0]    o_root,
    output logic                  o_last
);

    localparam int N  = ACC_W / 2;
    localparam int NW = $clog2(N + 1);
    localparam int TW = N + 4;

    logic            r_busy, r_done, r_out_valid;
    logic [NW-1:0]   r_cnt;
    logic [ACC_W-1:0] r_val;
    logic [N+1:0]    r_rem;
    logic [N-1:0]    r_root;
    logic [IW-1:0]   r_idx, r_out_idx;
    logic            r_last, r_out_last;
    logic [N-1:0]    r_out_root;

    logic [TW-1:0]   t_rem, t_trial, t_diff;
    logic            take, out_free, go;

    assign t_rem    = TW'({r_rem, r_val[ACC_W-1 -: 2]});
    assign t_trial  = TW'({r_root, 2'b01});
    assign t_diff   = t_rem - t_trial;
    assign o_job_ready = !r_busy && !r_done;
    assign take     = i_job_valid && o_job_ready;
    assign out_free = !r_out_valid || i_pop;
    assign go       = r_done && out_free;

    assign o_empty = !r_out_valid;
    assign o_idx   = r_out_idx;
    assign o_root  = r_out_root;
    assign o_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_val  <= i_job_acc;
            r_rem  <= '0;
            r_root <= '0;
            r_idx  <= i_job_idx;
            r_last <= i_job_last;
        end else if (r_busy) begin
            r_val <= r_val << 2;
            if (t_rem >= t_trial) begin
                r_rem  <= t_diff[N+1:0];
                r_root <= {r_root[N-2:0], 1'b1};
            end else begin
                r_rem  <= t_rem[N+1:0];
                r_root <= {r_root[N-2:0], 1'b0};
            end
        end
        if (go) begin
            r_out_idx  <= r_idx;
            r_out_root <= r_root;
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (go) begin
                r_done <= 1'b0;
            end
            if (go)         r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
        end
    end

endmodule

[hdl/bdts_checker.sv]
// ----------------------------------------------------------------------------
// bdts_checker
// Port-level checks on the scorer, bound to the top level.
// ----------------------------------------------------------------------------
module bdts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_push,
    input logic                          o_full,
    input logic                          i_last_item,
    input logic                          o_empty,
    input logic                          i_pop,
    input logic [bdts_pkg::CIDX_W-1:0]   o_candidate_index,
    input logic [bdts_pkg::DIST_W-1:0]   o_distance
);

    // reset leaves no result waiting
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result present after reset");

    // input side closes only after the batch's last item was taken
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_full) |-> $past(i_push && i_last_item))
        else $error("full raised without last item");

    // a waiting item stays until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> $stable(o_distance) && $stable(o_candidate_index))
        else $error("result changed while stalled");

endmodule

bind best_distance_threshold_scorer bdts_checker u_bdts_checker (.*);
